>>> design/assert_macros.svh
// Assertion macros used by the port-level checker, lcg_checker.
// Depends on nothing; included by file name only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a at this edge implies b at the same edge
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed: label");

// a at this edge implies b at the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed: label");

`endif

>>> design/lcg_pkg.sv
// Shared widths, register indexes, reset values and control structs of the LCG.
// Depends on nothing.
package lcg_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int PROD_WIDTH    = 2 * VALUE_WIDTH;
    localparam int CNT_WIDTH     = $clog2(PROD_WIDTH);
    localparam int CFG_IDX_WIDTH = 2;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_SEED       = 2'd0,
        REG_MULTIPLIER = 2'd1,
        REG_INCREMENT  = 2'd2,
        REG_MODULUS    = 2'd3
    } t_reg_idx;

    localparam logic [VALUE_WIDTH-1:0] RST_SEED       = VALUE_WIDTH'(5);
    localparam logic [VALUE_WIDTH-1:0] RST_MULTIPLIER = VALUE_WIDTH'(5);
    localparam logic [VALUE_WIDTH-1:0] RST_INCREMENT  = VALUE_WIDTH'(1);
    localparam logic [VALUE_WIDTH-1:0] RST_MODULUS    = VALUE_WIDTH'(16);

    typedef struct packed {
        logic load;      // request accepted: pick value, fill output register
        logic mul;       // form multiplier*value + increment
        logic div_step;  // one remainder bit
        logic div_last;  // final remainder bit, commit next value
    } t_ctrl_cmd;

    typedef struct packed {
        logic mod_zero;
    } t_ctrl_sts;

endpackage

>>> design/lcg_req_if.sv
// Request channel: valid/ready with the restart flag.
// Depends on nothing.
interface lcg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

>>> design/lcg_rsp_if.sv
// Result channel: valid/ready with the drawn value.
// Depends on lcg_pkg for the value width.
interface lcg_rsp_if;
    import lcg_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

>>> design/lcg_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on lcg_pkg for widths.
interface lcg_cfg_if;
    import lcg_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_WIDTH-1:0] index;
    logic [VALUE_WIDTH-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/lcg_ctrl.sv
// LCG controller: request handshake, output valid, and the multiply/remainder sequence.
// Depends on lcg_pkg.
module lcg_ctrl
    import lcg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_ready,
    output logic      o_rsp_valid,
    input  logic      i_rsp_ready,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_DIV  = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                 r_rsp_valid, n_rsp_valid;
    logic                 accept;
    logic                 last;

    assign o_req_ready = (r_state == S_IDLE) && (!r_rsp_valid || i_rsp_ready);
    assign accept      = i_req_valid && o_req_ready;
    assign last        = (r_cnt == CNT_WIDTH'(PROD_WIDTH - 1));
    assign o_rsp_valid = r_rsp_valid;

    always_comb begin
        o_cmd.load     = accept;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.div_last = (r_state == S_DIV) && last;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rsp_valid = r_rsp_valid;
        if (accept) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_cnt   = '0;
                n_state = i_sts.mod_zero ? S_IDLE : S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + CNT_WIDTH'(1);
                if (last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

>>> design/lcg_dp.sv
// LCG datapath: configuration registers, current value, multiply-add and
// bit-serial restoring remainder. Depends on lcg_pkg.
module lcg_dp
    import lcg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl_cmd                i_cmd,
    output t_ctrl_sts                o_sts,
    input  logic                     i_restart,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [VALUE_WIDTH-1:0]   i_cfg_data,
    output logic [VALUE_WIDTH-1:0]   o_random_value
);

    logic [VALUE_WIDTH-1:0] r_seed, r_mult, r_inc, r_mod;
    logic [VALUE_WIDTH-1:0] r_cur;
    logic [VALUE_WIDTH-1:0] r_out;
    logic [PROD_WIDTH-1:0]  r_prod;
    logic [VALUE_WIDTH-1:0] r_rem;

    logic [VALUE_WIDTH-1:0] start_value;
    logic [PROD_WIDTH-1:0]  prod_sum;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   trial_sub;
    logic [VALUE_WIDTH-1:0] n_rem;

    assign o_sts.mod_zero = (r_mod == '0);
    assign o_random_value = r_out;
    assign start_value    = i_restart ? r_seed : r_cur;

    // value < 2^W and multiplier, increment < 2^W keep the sum below 2^(2W)
    assign prod_sum = PROD_WIDTH'(r_mult) * PROD_WIDTH'(r_cur) + PROD_WIDTH'(r_inc);

    assign trial     = {r_rem, r_prod[PROD_WIDTH-1]};
    assign trial_sub = trial - {1'b0, r_mod};
    assign n_rem     = (trial >= {1'b0, r_mod}) ? trial_sub[VALUE_WIDTH-1:0]
                                                : trial[VALUE_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= RST_SEED;
            r_mult <= RST_MULTIPLIER;
            r_inc  <= RST_INCREMENT;
            r_mod  <= RST_MODULUS;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SEED:       r_seed <= i_cfg_data;
                REG_MULTIPLIER: r_mult <= i_cfg_data;
                REG_INCREMENT:  r_inc  <= i_cfg_data;
                REG_MODULUS:    r_mod  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= RST_SEED;
        end else if (i_cmd.load) begin
            r_cur <= start_value;
        end else if (i_cmd.mul && o_sts.mod_zero) begin
            r_cur <= prod_sum[VALUE_WIDTH-1:0];
        end else if (i_cmd.div_last) begin
            r_cur <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= start_value;
        end
        if (i_cmd.mul) begin
            r_prod <= prod_sum;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_prod <= {r_prod[PROD_WIDTH-2:0], 1'b0};
            r_rem  <= n_rem;
        end
    end

endmodule

>>> design/linear_congruential_generator.sv
// Linear congruential generator. Each accepted request returns the current value
// (or the seed, when restart is set) in the cycle after acceptance, held in an
// output register until taken, and then advances the state to
// (multiplier*value + increment) mod modulus. A request occupies the engine for
// the accept step, the 32x32 multiply-add and the restoring remainder unit, which
// retires one product bit per cycle over the whole double-width product. With a
// modulus of zero the remainder is skipped and the low 32 bits are kept. A new
// request is taken once the engine is idle and the previous result has been taken
// or is taken in that cycle. Configuration writes are always accepted and must only
// occur while the generator is idle; a seed write takes effect at the next restart.
module linear_congruential_generator
    import lcg_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    lcg_req_if.sink   i_req,
    lcg_rsp_if.source o_rsp,
    lcg_cfg_if.sink   i_cfg
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    assign i_cfg.ready = 1'b1;

    lcg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lcg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_restart      (i_req.restart),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_random_value (o_rsp.random_value)
    );

endmodule

>>> design/lcg_checker.sv
// Port-level checks for the LCG, bound to the top level.
// Depends on lcg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcg_checker
    import lcg_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_req_valid,
    input logic                   i_req_ready,
    input logic                   i_rsp_valid,
    input logic                   i_rsp_ready,
    input logic [VALUE_WIDTH-1:0] i_rsp_value
);

    logic req_acc;
    logic rsp_stall;

    assign req_acc   = i_req_valid && i_req_ready;
    assign rsp_stall = i_rsp_valid && !i_rsp_ready;

    `ASSERT_NEXT(a_rsp_valid_hold, i_clk, i_rst_n, rsp_stall, i_rsp_valid)
    `ASSERT_NEXT(a_rsp_value_hold, i_clk, i_rst_n, rsp_stall, $stable(i_rsp_value))
    `ASSERT_IMPLIES(a_no_req_over_stall, i_clk, i_rst_n, req_acc, !rsp_stall)
    `ASSERT_NEXT(a_rsp_after_req, i_clk, i_rst_n, req_acc, i_rsp_valid && !i_req_ready)

endmodule

bind linear_congruential_generator lcg_checker u_lcg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_value (o_rsp.random_value)
);

>>> verif/lcg_draw_checker.sv
// Watches the request, result and register-write channels of the LCG and checks every drawn value.
// Keeps its own copy of the generator registers and state to work out the expected value of each draw.
// Depends on lcg_pkg and the lcg_req_if, lcg_rsp_if and lcg_cfg_if interfaces.
module lcg_draw_checker
    import lcg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lcg_req_if   i_req,
    lcg_rsp_if   i_rsp,
    lcg_cfg_if   i_cfg,
    output int   o_pending,
    output int   o_mismatches,
    output int   o_checked
);

    logic [VALUE_WIDTH-1:0] seed_r;
    logic [VALUE_WIDTH-1:0] mult_r;
    logic [VALUE_WIDTH-1:0] incr_r;
    logic [VALUE_WIDTH-1:0] mod_r;
    logic [VALUE_WIDTH-1:0] state_r;
    logic [VALUE_WIDTH-1:0] drawn_q[$];
    int                     mismatch_cnt;
    int                     checked_cnt;

    // Exact (mult*x + incr) mod modulus; modulus 0 keeps the low bits.
    function automatic logic [VALUE_WIDTH-1:0] lcg_next(input logic [VALUE_WIDTH-1:0] x);
        logic [PROD_WIDTH-1:0] full;
        full = PROD_WIDTH'(mult_r) * PROD_WIDTH'(x) + PROD_WIDTH'(incr_r);
        if (mod_r == '0) begin
            return full[VALUE_WIDTH-1:0];
        end
        return VALUE_WIDTH'(full % PROD_WIDTH'(mod_r));
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_WIDTH-1:0] want,
                                   input logic [VALUE_WIDTH-1:0] got);
        $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
        mismatch_cnt++;
    endtask

    initial begin
        mismatch_cnt = 0;
        checked_cnt  = 0;
        o_pending    = 0;
        o_mismatches = 0;
        o_checked    = 0;
    end

    always @(posedge i_clk) begin
        logic [VALUE_WIDTH-1:0] want;
        if (!i_rst_n) begin
            seed_r  = RST_SEED;
            mult_r  = RST_MULTIPLIER;
            incr_r  = RST_INCREMENT;
            mod_r   = RST_MODULUS;
            state_r = RST_SEED;
            drawn_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_SEED:       seed_r = i_cfg.data;
                    REG_MULTIPLIER: mult_r = i_cfg.data;
                    REG_INCREMENT:  incr_r = i_cfg.data;
                    REG_MODULUS:    mod_r  = i_cfg.data;
                    default: ;
                endcase
            end
            // result first: a request taken in the same cycle cannot be this result
            if (i_rsp.valid && i_rsp.ready) begin
                if (drawn_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, i_rsp.random_value);
                end else begin
                    want = drawn_q.pop_front();
                    checked_cnt++;
                    if (i_rsp.random_value !== want) begin
                        report_mismatch("random_value", want, i_rsp.random_value);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.restart) begin
                    state_r = seed_r;
                end
                drawn_q.push_back(state_r);
                state_r = lcg_next(state_r);
            end
        end
        o_pending    <= drawn_q.size();
        o_mismatches <= mismatch_cnt;
        o_checked    <= checked_cnt;
    end

endmodule

>>> verif/tb.sv
// Top of the LCG testbench: clock, reset, request and register-write stimulus, result back-pressure.
// Directed corner draws first, then random settings under several idle and stall mixes.
// Depends on lcg_pkg, the channel interfaces, linear_congruential_generator and lcg_draw_checker.
module tb;
    import lcg_pkg::*;

    localparam int ENGINE_CYCLES = 66;
    localparam int HOLDOFF       = ENGINE_CYCLES + 14;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int PHASES        = 16;
    localparam int PHASE_DRAWS   = 100;

    logic i_clk;
    logic i_rst_n;

    lcg_req_if req_if();
    lcg_rsp_if rsp_if();
    lcg_cfg_if cfg_if();

    int pending;
    int mismatches;
    int checked;
    int idle_pct;
    int stall_pct;
    int n_draws;
    int n_restarts;
    int n_settings;
    int quiet_cycles;

    linear_congruential_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    lcg_draw_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .i_cfg        (cfg_if),
        .o_pending    (pending),
        .o_mismatches (mismatches),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_MAX);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic draw(input logic restart);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.restart <= restart;
        do @(posedge i_clk); while (!req_if.ready);
        n_draws++;
        if (restart) begin
            n_restarts++;
        end
    endtask

    // stop requesting until every drawn value is back, then let the engine finish
    task automatic settle(input int holdoff);
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (holdoff) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [VALUE_WIDTH-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    task automatic configure(input logic [VALUE_WIDTH-1:0] seed, input logic [VALUE_WIDTH-1:0] mult,
                             input logic [VALUE_WIDTH-1:0] incr, input logic [VALUE_WIDTH-1:0] modv);
        settle(HOLDOFF);
        write_reg(REG_SEED, seed);
        write_reg(REG_MULTIPLIER, mult);
        write_reg(REG_INCREMENT, incr);
        write_reg(REG_MODULUS, modv);
        cfg_if.valid <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [VALUE_WIDTH-1:0] pick_operand();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return VALUE_WIDTH'(1);
            3: return VALUE_WIDTH'($urandom_range(255));
            default: return VALUE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] pick_modulus();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            2: return VALUE_WIDTH'(1);
            3, 4, 5, 6, 7: return VALUE_WIDTH'($urandom_range(255, 2));
            default: return VALUE_WIDTH'($urandom);
        endcase
    endfunction

    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.restart = 1'b0;
        rsp_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = REG_SEED;
        cfg_if.data    = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        n_draws        = 0;
        n_restarts     = 0;
        n_settings     = 1;
        quiet_cycles   = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: state starts at the seed
        draw(1'b0);
        draw(1'b0);
        draw(1'b0);
        draw(1'b1);
        draw(1'b0);
        // all registers at their maximum
        configure('1, '1, '1, '1);
        draw(1'b1);
        draw(1'b0);
        draw(1'b0);
        // modulus zero wraps at the register width
        configure('1, '1, '1, '0);
        draw(1'b0);
        draw(1'b0);
        draw(1'b1);
        draw(1'b0);
        // seed above modulus comes back unreduced
        configure(VALUE_WIDTH'(100), VALUE_WIDTH'(3), '0, VALUE_WIDTH'(7));
        draw(1'b1);
        draw(1'b0);
        draw(1'b0);
        // modulus one
        configure(VALUE_WIDTH'(100), VALUE_WIDTH'(3), '0, VALUE_WIDTH'(1));
        draw(1'b1);
        draw(1'b0);
        // seed write alone leaves the state alone until restart
        settle(HOLDOFF);
        write_reg(REG_SEED, VALUE_WIDTH'(12345));
        cfg_if.valid <= 1'b0;
        draw(1'b0);
        draw(1'b1);
        draw(1'b0);
        // seed, multiplier and increment zero, modulus one
        configure('0, '0, '0, '1);
        draw(1'b1);
        draw(1'b0);

        for (int p = 0; p < PHASES; p++) begin
            configure(pick_operand(), pick_operand(), pick_operand(), pick_modulus());
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            for (int k = 0; k < PHASE_DRAWS; k++) begin
                draw($urandom_range(7) == 0);
                if ($urandom_range(39) == 0) begin
                    settle(0);
                end
            end
        end

        settle(HOLDOFF);
        $display("Drew %0d values (%0d with restart, %0d checked) over %0d register settings,",
                 n_draws, n_restarts, checked, n_settings);
        $display("modulus 0, 1 and all-ones and seed above modulus included, %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
